// ===== rtl/core/qaa_pkg.sv =====
// ----------------------------------------------------------------------------
// qaa_pkg
// Shared types and constants of the quadtree area allocator.
// ----------------------------------------------------------------------------
package qaa_pkg;

	localparam int FLAG_W         = 8;
	localparam int SCALE_W        = 3;
	localparam int NODE_W         = 13;
	localparam int COORD_W        = 7;
	localparam int LVL_W          = 4;
	localparam int DEF_MAX_SCALE  = 6;
	localparam int DEF_NODE_COUNT = 5461;

	localparam logic [FLAG_W-1:0] FLAGS_FREE = 8'hFF;
	localparam logic [FLAG_W-1:0] FLAGS_USED = 8'h00;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_ROOT_RD,
		S_ROOT_CHK,
		S_DESC_LVL,
		S_DESC_RD,
		S_DESC_CHK,
		S_ALLOC_WR,
		S_REL_WR,
		S_REL_LVL,
		S_UP_START,
		S_UP_RD,
		S_UP_ACC,
		S_UP_PRD,
		S_UP_CMP
	} state_t;

	typedef enum logic [2:0] {
		A_CLR,
		A_ROOT,
		A_CHILD_NODE,
		A_CHILD_PAR,
		A_CUR,
		A_PARENT
	} addr_sel_t;

	typedef enum logic [1:0] {
		WD_ONES,
		WD_ZERO,
		WD_NV
	} wd_sel_t;

	typedef struct packed {
		addr_sel_t addr_sel;
		logic      we;
		wd_sel_t   wd_sel;
		logic      clr_inc;
		logic      ld_alloc;
		logic      ld_rel;
		logic      q_clr;
		logic      q_inc;
		logic      take;
		logic      bnd_step;
		logic      up_init;
		logic      acc;
		logic      ascend;
		logic      mark;
		logic      emit_ok;
		logic      emit_bad;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic func;
		logic rel_ok;
		logic root_ok;
		logic scale_zero;
		logic desc_fits;
		logic child_hit;
		logic q_last;
		logic desc_last;
		logic rel_above;
		logic up_go;
		logic up_fits;
		logic nv_same;
		logic is_alloc;
	} sts_t;

endpackage

// ===== rtl/core/quadtree_area_allocator.sv =====
// ----------------------------------------------------------------------------
// quadtree_area_allocator
// Two-dimensional buddy allocator over a square grid kept as a quadtree.
// ----------------------------------------------------------------------------
// Command channel: a transfer happens on a rising edge with start high and
// busy low. func 0 allocates a block of req_scale; func 1 releases the block
// at release_node. Only one command is in work at a time.
// Result channel: each allocate gives exactly one result, held for a single
// cycle with done high (valid_res, atom_x, atom_y, node_index). A failed
// allocate reports valid_res low with zero fields. A release gives nothing.
// The receiver cannot stall; results must be taken when done is high.
// Timing is set by the single-port flag memory, one read or write a cycle:
// allocate reads and checks the root, then on the way down reads and
// checks each child probed at each level, writes the block as used, then
// repairs the ancestors, reading the four children of each, until one
// needs no change or the root is reached. A release writes the block
// free, finds its level, then repairs the ancestors in the same manner.
// Reset: the flag store is swept to all-free, one entry a cycle, over all
// NODE_COUNT entries (5461 by default) with busy high.
// ----------------------------------------------------------------------------
module quadtree_area_allocator import qaa_pkg::*; #(
	parameter int MAX_SCALE  = DEF_MAX_SCALE,
	parameter int NODE_COUNT = DEF_NODE_COUNT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               func,
	input  logic [SCALE_W-1:0] req_scale,
	input  logic [NODE_W-1:0]  release_node,
	output logic               done,
	output logic               valid_res,
	output logic [COORD_W-1:0] atom_x,
	output logic [COORD_W-1:0] atom_y,
	output logic [NODE_W-1:0]  node_index
);

	cmd_t cmd;
	sts_t sts;

	qaa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	qaa_dpath #(
		.MAX_SCALE  (MAX_SCALE),
		.NODE_COUNT (NODE_COUNT)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.func         (func),
		.req_scale    (req_scale),
		.release_node (release_node),
		.done         (done),
		.valid_res    (valid_res),
		.atom_x       (atom_x),
		.atom_y       (atom_y),
		.node_index   (node_index)
	);

	// a result only follows work in progress
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a command in work");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_alloc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !func) |=> busy)
		else $error("allocate transfer did not start work");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !valid_res) |-> (atom_x == '0 && atom_y == '0 && node_index == '0))
		else $error("failed allocate with nonzero fields");

endmodule

// ===== rtl/core/qaa_ctrl.sv =====
// ----------------------------------------------------------------------------
// qaa_ctrl
// Sequencer: clear sweep, allocate descent, release level search and
// ancestor repair, issued to the datapath as per-cycle commands.
// ----------------------------------------------------------------------------
module qaa_ctrl import qaa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_n;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (sts.clr_last) state_n = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					if (!sts.func) state_n = S_ROOT_RD;
					else if (sts.rel_ok) state_n = S_REL_WR;
				end
			end
			S_ROOT_RD:  state_n = S_ROOT_CHK;
			S_ROOT_CHK: begin
				if (!sts.root_ok) state_n = S_IDLE;
				else if (sts.scale_zero) state_n = S_ALLOC_WR;
				else state_n = S_DESC_LVL;
			end
			S_DESC_LVL: state_n = sts.desc_fits ? S_DESC_RD : S_IDLE;
			S_DESC_RD:  state_n = S_DESC_CHK;
			S_DESC_CHK: begin
				if (sts.child_hit) state_n = sts.desc_last ? S_ALLOC_WR : S_DESC_LVL;
				else if (sts.q_last) state_n = S_IDLE;
				else state_n = S_DESC_RD;
			end
			S_ALLOC_WR: state_n = sts.scale_zero ? S_IDLE : S_UP_START;
			S_REL_WR:   state_n = S_REL_LVL;
			S_REL_LVL: begin
				if (!sts.rel_above) state_n = S_UP_START;
			end
			S_UP_START: state_n = (sts.up_go && sts.up_fits) ? S_UP_RD : S_IDLE;
			S_UP_RD:    state_n = S_UP_ACC;
			S_UP_ACC:   state_n = sts.q_last ? S_UP_PRD : S_UP_RD;
			S_UP_PRD:   state_n = S_UP_CMP;
			S_UP_CMP:   state_n = sts.nv_same ? S_IDLE : S_UP_START;
			default:    state_n = S_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.addr_sel = A_ROOT;
		cmd.wd_sel   = WD_ONES;
		unique case (state_q)
			S_CLEAR: begin
				cmd.addr_sel = A_CLR;
				cmd.we       = 1'b1;
				cmd.clr_inc  = 1'b1;
			end
			S_IDLE: begin
				if (start) begin
					cmd.ld_alloc = !sts.func;
					cmd.ld_rel   = sts.func && sts.rel_ok;
				end
			end
			S_ROOT_RD: cmd.addr_sel = A_ROOT;
			S_ROOT_CHK: begin
				cmd.emit_bad = !sts.root_ok;
			end
			S_DESC_LVL: begin
				cmd.q_clr    = 1'b1;
				cmd.emit_bad = !sts.desc_fits;
			end
			S_DESC_RD: cmd.addr_sel = A_CHILD_NODE;
			S_DESC_CHK: begin
				cmd.take     = sts.child_hit;
				cmd.q_inc    = !sts.child_hit && !sts.q_last;
				cmd.emit_bad = !sts.child_hit && sts.q_last;
			end
			S_ALLOC_WR: begin
				cmd.addr_sel = A_CUR;
				cmd.we       = 1'b1;
				cmd.wd_sel   = WD_ZERO;
				cmd.mark     = 1'b1;
				cmd.emit_ok  = sts.scale_zero;
			end
			S_REL_WR: begin
				cmd.addr_sel = A_CUR;
				cmd.we       = 1'b1;
				cmd.wd_sel   = WD_ONES;
			end
			S_REL_LVL: begin
				cmd.bnd_step = sts.rel_above;
			end
			S_UP_START: begin
				cmd.up_init = sts.up_go && sts.up_fits;
				cmd.emit_ok = !(sts.up_go && sts.up_fits) && sts.is_alloc;
			end
			S_UP_RD: cmd.addr_sel = A_CHILD_PAR;
			S_UP_ACC: begin
				cmd.acc   = 1'b1;
				cmd.q_inc = !sts.q_last;
			end
			S_UP_PRD: cmd.addr_sel = A_PARENT;
			S_UP_CMP: begin
				cmd.addr_sel = A_PARENT;
				cmd.wd_sel   = WD_NV;
				cmd.we       = !sts.nv_same;
				cmd.ascend   = !sts.nv_same;
				cmd.emit_ok  = sts.nv_same && sts.is_alloc;
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/core/qaa_dpath.sv =====
// ----------------------------------------------------------------------------
// qaa_dpath
// Flag store, walk registers, address generation and result registers.
// ----------------------------------------------------------------------------
module qaa_dpath import qaa_pkg::*; #(
	parameter int MAX_SCALE  = DEF_MAX_SCALE,
	parameter int NODE_COUNT = DEF_NODE_COUNT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic               func,
	input  logic [SCALE_W-1:0] req_scale,
	input  logic [NODE_W-1:0]  release_node,
	output logic               done,
	output logic               valid_res,
	output logic [COORD_W-1:0] atom_x,
	output logic [COORD_W-1:0] atom_y,
	output logic [NODE_W-1:0]  node_index
);

	localparam int AW = $clog2(NODE_COUNT);
	localparam int EW = AW + 3;
	localparam int XW = MAX_SCALE + 1;
	localparam int CW = (AW > NODE_W) ? AW : NODE_W;

	logic [FLAG_W-1:0]  flags_q [NODE_COUNT];
	logic [FLAG_W-1:0]  rdata_q;
	logic [AW-1:0]      clr_q;
	logic [AW-1:0]      cur_q, parent_q, res_node_q;
	logic [1:0]         q_q;
	logic [LVL_W-1:0]   lvl_q;
	logic [SCALE_W-1:0] scale_q;
	logic [XW-1:0]      x_q, y_q;
	logic [FLAG_W-1:0]  any_q, all_q;
	logic [EW-1:0]      bnd_q;
	logic               is_alloc_q;
	logic               done_q, valid_q;
	logic [COORD_W-1:0] out_x_q, out_y_q;
	logic [NODE_W-1:0]  out_node_q;

	logic [AW-1:0]      mem_addr, pnext;
	logic [FLAG_W-1:0]  mem_wd, nv;
	logic [FLAG_W:0]    lmask;
	logic [EW-1:0]      child_n, child_p;
	logic [XW-1:0]      stride;

	// first child is 4n+1, probe q adds to it
	assign child_n = (EW'(cur_q) << 2) + EW'(1) + EW'(q_q);
	assign child_p = (EW'(parent_q) << 2) + EW'(1) + EW'(q_q);
	assign pnext   = (cur_q - AW'(1)) >> 2;
	assign stride  = XW'(1) << (MAX_SCALE - int'(lvl_q));

	always_comb begin
		unique case (cmd.addr_sel)
			A_CLR:        mem_addr = clr_q;
			A_ROOT:       mem_addr = '0;
			A_CHILD_NODE: mem_addr = child_n[AW-1:0];
			A_CHILD_PAR:  mem_addr = child_p[AW-1:0];
			A_CUR:        mem_addr = cur_q;
			A_PARENT:     mem_addr = parent_q;
			default:      mem_addr = '0;
		endcase
	end

	// parent word: OR of children, low bits dropped when the level's own
	// scale is not free in all four
	always_comb begin
		lmask = ((FLAG_W + 1)'(1) << lvl_q) - (FLAG_W + 1)'(1);
		nv    = any_q;
		if (lvl_q != '0 && lvl_q <= LVL_W'(FLAG_W) &&
		    !all_q[3'(lvl_q - LVL_W'(1))]) begin
			nv = any_q & ~lmask[FLAG_W-1:0];
		end
	end

	always_comb begin
		unique case (cmd.wd_sel)
			WD_ONES: mem_wd = FLAGS_FREE;
			WD_ZERO: mem_wd = FLAGS_USED;
			WD_NV:   mem_wd = nv;
			default: mem_wd = FLAGS_FREE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.we) flags_q[mem_addr] <= mem_wd;
		rdata_q <= flags_q[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			done_q <= 1'b0;
		end else begin
			if (cmd.clr_inc) clr_q <= clr_q + AW'(1);
			done_q <= cmd.emit_ok || cmd.emit_bad;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_alloc) begin
			scale_q    <= req_scale;
			cur_q      <= '0;
			x_q        <= '0;
			y_q        <= '0;
			lvl_q      <= '0;
			is_alloc_q <= 1'b1;
		end
		if (cmd.ld_rel) begin
			cur_q      <= AW'(release_node);
			lvl_q      <= '0;
			bnd_q      <= EW'(1);
			is_alloc_q <= 1'b0;
		end
		if (cmd.q_clr) q_q <= '0;
		if (cmd.q_inc) q_q <= q_q + 2'd1;
		if (cmd.take) begin
			cur_q <= child_n[AW-1:0];
			if (q_q[0]) x_q <= x_q + stride;
			if (q_q[1]) y_q <= y_q + stride;
			lvl_q <= lvl_q + LVL_W'(1);
		end
		if (cmd.bnd_step) begin
			bnd_q <= (bnd_q << 2) + EW'(1);
			lvl_q <= lvl_q + LVL_W'(1);
		end
		if (cmd.mark) res_node_q <= cur_q;
		if (cmd.up_init) begin
			parent_q <= pnext;
			q_q      <= '0;
			any_q    <= FLAGS_USED;
			all_q    <= FLAGS_FREE;
		end
		if (cmd.acc) begin
			any_q <= any_q | rdata_q;
			all_q <= all_q & rdata_q;
		end
		if (cmd.ascend) begin
			cur_q <= parent_q;
			lvl_q <= lvl_q - LVL_W'(1);
		end
		if (cmd.emit_ok) begin
			valid_q    <= 1'b1;
			out_x_q    <= COORD_W'(x_q);
			out_y_q    <= COORD_W'(y_q);
			out_node_q <= NODE_W'(cmd.mark ? cur_q : res_node_q);
		end else if (cmd.emit_bad) begin
			valid_q    <= 1'b0;
			out_x_q    <= '0;
			out_y_q    <= '0;
			out_node_q <= '0;
		end
	end

	always_comb begin
		sts.clr_last   = (clr_q == AW'(NODE_COUNT - 1));
		sts.func       = func;
		sts.rel_ok     = (CW'(release_node) < CW'(NODE_COUNT));
		sts.root_ok    = ({1'b0, scale_q} <= (SCALE_W + 1)'(MAX_SCALE)) && rdata_q[scale_q];
		sts.scale_zero = (scale_q == '0);
		sts.desc_fits  = ((EW'(cur_q) << 2) + EW'(4)) < EW'(NODE_COUNT);
		sts.child_hit  = rdata_q[scale_q];
		sts.q_last     = &q_q;
		sts.desc_last  = ((lvl_q + LVL_W'(1)) == LVL_W'(scale_q));
		sts.rel_above  = (EW'(cur_q) >= bnd_q);
		sts.up_go      = (cur_q != '0) && (lvl_q != '0);
		sts.up_fits    = ((EW'(pnext) << 2) + EW'(4)) < EW'(NODE_COUNT);
		sts.nv_same    = (rdata_q == nv);
		sts.is_alloc   = is_alloc_q;
	end

	assign done       = done_q;
	assign valid_res  = valid_q;
	assign atom_x     = out_x_q;
	assign atom_y     = out_y_q;
	assign node_index = out_node_q;

endmodule
